/* hdl/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared geometry, codes and controller/datapath interface types for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_WIDTH  = 8;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS + TAB_WIDTH);
    localparam int ROW_W  = $clog2(ROWS + 1);

    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int POS_W     = 11;
    localparam int INDEX_W   = 11;
    localparam int CFG_IDX_W = 4;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR = 4'd1;

    typedef enum logic [1:0] {
        SWEEP_NONE,
        SWEEP_CLEAR,
        SWEEP_SCROLL
    } sweep_t;

    typedef struct packed {
        logic   load_item;
        logic   exec;
        sweep_t sweep;
        logic   cnt_clr;
        logic   out_load;
    } tcw_cmd_t;

    typedef struct packed {
        logic op_read;
        logic need_scroll;
        logic cnt_last_cell;
        logic cnt_end;
    } tcw_sts_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * COLUMNS + int'(col));
    endfunction

endpackage

/* hdl/tcw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/tcw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: reset clear pass, request decode, scroll sweep and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  tcw_pkg::tcw_sts_t sts,
    output tcw_pkg::tcw_cmd_t cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.sweep     = SWEEP_NONE;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.sweep = SWEEP_CLEAR;
                if (sts.cnt_last_cell) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.cnt_clr = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.need_scroll ? ST_SCROLL : ST_DONE;
            end
            ST_SCROLL: begin
                cmd.sweep = SWEEP_SCROLL;
                if (sts.cnt_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR || state_reg == ST_SCROLL) |-> !s_tready)
        else $error("request accepted during store sweep");

    a_scroll_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL && $past(state_reg) != ST_SCROLL) |->
        ($past(state_reg) == ST_EXEC && $past(sts.need_scroll)))
        else $error("scroll started without overflow");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");

endmodule

/* hdl/tcw_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: attribute registers, cursor, screen store, sweep counter and
// result register.
// ----------------------------------------------------------------------------
module tcw_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tcw_pkg::tcw_cmd_t                  cmd,
    output tcw_pkg::tcw_sts_t                  sts,
    input  logic [tcw_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               s_tuser,
    output logic [tcw_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]         cfg_data
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0]    text_attr_reg, blank_attr_reg;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_adv;
    logic                 row_inc, wr_char;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 op_read_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic [INDEX_W-1:0]   index_reg;
    logic                 in_range_reg, scrolled_reg;
    logic [M_TDATA_W-1:0] out_reg;
    logic [COL_W-1:0]     col_plus, col_tab;
    logic                 idx_ok;

    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [CELL_W-1:0]    ram_wdata, ram_rdata;
    logic [CHAR_W-1:0]    rd_char;
    logic [ATTR_W-1:0]    rd_attr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attr_reg  <= ATTR_RESET;
            blank_attr_reg <= ATTR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TEXT_ATTR:  text_attr_reg  <= cfg_data;
                CFG_BLANK_ATTR: blank_attr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // cursor update for a put
    assign col_plus = col_reg + COL_W'(1);
    assign col_tab  = col_reg - (col_reg % COL_W'(TAB_WIDTH)) + COL_W'(TAB_WIDTH);
    assign idx_ok   = (index_reg < INDEX_W'(CELL_COUNT));

    always_comb begin
        col_next = col_reg;
        row_inc  = 1'b0;
        wr_char  = 1'b0;
        unique case (char_reg)
            CH_LF: begin
                col_next = '0;
                row_inc  = 1'b1;
            end
            CH_TAB: begin
                if (col_tab >= COL_W'(COLUMNS)) begin
                    col_next = '0;
                    row_inc  = 1'b1;
                end else begin
                    col_next = col_tab;
                end
            end
            CH_CR: col_next = '0;
            default: begin
                wr_char = 1'b1;
                if (col_plus >= COL_W'(COLUMNS)) begin
                    col_next = '0;
                    row_inc  = 1'b1;
                end else begin
                    col_next = col_plus;
                end
            end
        endcase
    end

    assign row_adv = row_reg + ROW_W'(row_inc);

    assign sts.op_read       = op_read_reg;
    assign sts.need_scroll   = !op_read_reg && (row_adv > ROW_W'(ROWS - 1));
    assign sts.cnt_last_cell = (cnt_reg == CNT_W'(CELL_COUNT - 1));
    assign sts.cnt_end       = (cnt_reg == CNT_W'(CELL_COUNT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.exec && !op_read_reg) begin
                col_reg <= col_next;
                row_reg <= sts.need_scroll ? ROW_W'(ROWS - 1) : row_adv;
            end
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end else if (cmd.sweep != SWEEP_NONE) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_read_reg <= s_tuser;
            char_reg    <= s_tdata[CHAR_W-1:0];
            index_reg   <= s_tdata[CHAR_W +: INDEX_W];
        end
        if (cmd.exec) begin
            in_range_reg <= idx_ok;
            scrolled_reg <= sts.need_scroll;
        end
    end

    // store port selection: clear pass, scroll sweep or single access
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cell_addr(row_reg, col_reg);
        ram_wdata = {text_attr_reg, char_reg};
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(index_reg);
        unique case (cmd.sweep)
            SWEEP_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(cnt_reg);
                ram_wdata = {ATTR_RESET, CHAR_W'(0)};
            end
            SWEEP_SCROLL: begin
                // read runs one line ahead of the count; write stores the registered read data at count - 1
                ram_we    = (cnt_reg != '0);
                ram_waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                ram_wdata = (cnt_reg <= CNT_W'(CELL_COUNT - COLUMNS)) ? ram_rdata
                                                                      : {blank_attr_reg,
                                                                         CHAR_W'(0)};
                ram_re    = (cnt_reg < CNT_W'(CELL_COUNT - COLUMNS));
                ram_raddr = ADDR_W'(cnt_reg + CNT_W'(COLUMNS));
            end
            default: begin
                ram_we = cmd.exec && !op_read_reg && wr_char;
                ram_re = cmd.exec && op_read_reg && idx_ok;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_char = (op_read_reg && in_range_reg) ? ram_rdata[CHAR_W-1:0] : '0;
    assign rd_attr = (op_read_reg && in_range_reg) ? ram_rdata[CELL_W-1:CHAR_W] : '0;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= M_TDATA_W'({!op_read_reg && scrolled_reg, rd_attr, rd_char,
                                   POS_W'(cell_addr(row_reg, col_reg))});
        end
    end

    assign m_tdata = out_reg;

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < COL_W'(COLUMNS))
        else $error("cursor column past last column");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg < ROW_W'(ROWS))
        else $error("cursor row past last row");

    a_single_write_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && op_read_reg) |-> !ram_we)
        else $error("store written by a read request");

endmodule

/* hdl/text_console_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console engine: 80x25 screen store of character/attribute cells with a
// cursor, control characters and scroll.
// ----------------------------------------------------------------------------
// After reset the store is cleared one cell a cycle, during which s_tready
// stays low (configuration writes are still taken). Requests are handled one
// at a time: an accepted put or read is executed in ST_EXEC and its result is
// registered onto m_tdata in ST_DONE once any pending result has been taken.
// The next request can be taken the cycle after the result is registered,
// even while that result waits on m_tready. A put that moves below the last row
// also sweeps the whole store through its single write port, copying each line
// up and blanking the bottom line, before its result is registered.
// Attribute registers should only be written while the block is idle.
module text_console_writer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]      s_tdata,   // char_code, cell_index, zero pad
    input  logic                               s_tuser,   // op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]      m_tdata,   // cursor_pos, cell_char,
                                                          // cell_attr, scrolled, zero pad
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]         cfg_data
);
    import tcw_pkg::*;

    tcw_cmd_t cmd;
    tcw_sts_t sts;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
